>>> rtl/core/iapsg_pkg.sv
// ============================================================================
// iapsg_pkg
// Shared widths, constants and handshake structs for the isochronous audio
// packet size generator and its serial arithmetic units.
// ============================================================================
package iapsg_pkg;

    // field widths
    localparam int RATE_W     = 20;
    localparam int IPS_W      = 13;
    localparam int FRAME_W    = 8;
    localparam int EP_W       = 12;
    localparam int BYTES_W    = 17;
    localparam int FRAMES_W   = 10;
    localparam int CFG_IDX_W  = 2;

    // serial divider sizes: dividend holds remainder plus rate
    localparam int DIVIDEND_W = RATE_W + 1;
    localparam int DIVISOR_W  = IPS_W;
    localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

    // serial multiplier sizes: one multiplier bit per step
    localparam int MUL_STEP_W = $clog2(FRAME_W + 1);

    // result field limits
    localparam logic [BYTES_W-1:0]  BYTES_FIELD_MAX  = {BYTES_W{1'b1}};
    localparam logic [FRAMES_W-1:0] FRAMES_FIELD_MAX = {FRAMES_W{1'b1}};

    // register reset values
    localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(48000);
    localparam logic [IPS_W-1:0]   IPS_RESET   = IPS_W'(8000);
    localparam logic [FRAME_W-1:0] FRAME_RESET = FRAME_W'(8);
    localparam logic [EP_W-1:0]    EP_RESET    = '0;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_RATE          = 2'd0,
        CFG_INTERVALS_PER_SECOND = 2'd1,
        CFG_FRAME_BYTES          = 2'd2,
        CFG_ENDPOINT_MAX_PACKET  = 2'd3
    } cfg_index_t;

    // divider request and response
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
        logic [STEP_W-1:0]     steps;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } div_rsp_t;

    // multiplier request and response
    typedef struct packed {
        logic                start;
        logic [FRAMES_W-1:0] mcand;
        logic [FRAME_W-1:0]  mplier;
    } mul_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [BYTES_W-1:0] product;
    } mul_rsp_t;

endpackage

>>> rtl/core/iapsg_serial_div.sv
// ============================================================================
// iapsg_serial_div
// Restoring radix-2 divider, one quotient bit per cycle. The dividend comes
// left-aligned in its register and steps gives how many bits to retire.
// ============================================================================
module iapsg_serial_div (
    input  logic                clk,
    input  logic                rst_n,
    input  iapsg_pkg::div_req_t req,
    output iapsg_pkg::div_rsp_t rsp
);
    import iapsg_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [STEP_W-1:0]     count_reg;
    logic [STEP_W-1:0]     count_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [DIVISOR_W-1:0]  divisor_next;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // one restoring step
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = (trial >= {1'b0, divisor_reg});

    // sequencing
    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (req.start)
        begin
            busy_next    = 1'b1;
            count_next   = req.steps;
            quo_next     = req.dividend;
            rem_next     = '0;
            divisor_next = req.divisor;
        end
        else if (busy_reg)
        begin
            quo_next   = {quo_reg[DIVIDEND_W-2:0], fits};
            rem_next   = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            count_next = count_reg - STEP_W'(1);
            if (count_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

>>> rtl/core/iapsg_serial_mul.sv
// ============================================================================
// iapsg_serial_mul
// Shift-and-add multiplier, one multiplier bit per cycle, product kept to
// the packet byte field width and held until the next start.
// ============================================================================
module iapsg_serial_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  iapsg_pkg::mul_req_t req,
    output iapsg_pkg::mul_rsp_t rsp
);
    import iapsg_pkg::*;

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [MUL_STEP_W-1:0] count_reg;
    logic [MUL_STEP_W-1:0] count_next;
    logic [BYTES_W-1:0]    mcand_reg;
    logic [BYTES_W-1:0]    mcand_next;
    logic [FRAME_W-1:0]    mplier_reg;
    logic [FRAME_W-1:0]    mplier_next;
    logic [BYTES_W-1:0]    prod_reg;
    logic [BYTES_W-1:0]    prod_next;

    // sequencing and add step
    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        count_next  = count_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        prod_next   = prod_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            count_next  = MUL_STEP_W'(FRAME_W);
            mcand_next  = BYTES_W'(req.mcand);
            mplier_next = req.mplier;
            prod_next   = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                prod_next = prod_reg + mcand_reg;
            mcand_next  = {mcand_reg[BYTES_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[FRAME_W-1:1]};
            count_next  = count_reg - MUL_STEP_W'(1);
            if (count_reg == MUL_STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        prod_reg   <= prod_next;
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = prod_reg;

endmodule

>>> rtl/core/iso_audio_packet_size_generator_unit.sv
// ============================================================================
// iso_audio_packet_size_generator_unit
// Per-interval isochronous audio packet size generator with fractional
// sample-rate remainder and whole-frame packet limits.
// ============================================================================
// Usage:
//   Send one transfer on the input channel (in_valid/in_stall, field restart)
//   per service interval. Each one yields exactly one transfer on the output
//   channel (out_valid/out_stall) with packet_bytes, packet_frames and
//   was_clamped. restart clears the rate remainder before the interval.
//   Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data,
//   cfg_ready is always high; write only while no interval is in flight.
//   The work runs through one bit-serial divider three or four times
//   (remainder division, nominal ceiling, endpoint frames when an endpoint
//   limit is set, field cap, up to 21 steps each) and then an 8-step serial
//   multiplier. A new interval is accepted only once the last one has left
//   its result in the output register.
//   The result sits in an output register: a stalled receiver holds it there
//   while the next interval is already accepted and computed; that one then
//   waits until the held result is taken.
//   Reset: registers return to 48000 Hz, 8000 intervals/s, 8-byte frames,
//   no endpoint limit; the remainder clears and both channels go idle.
// ============================================================================
module iso_audio_packet_size_generator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // interval input
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            restart,
    // packet size output
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [iapsg_pkg::BYTES_W-1:0]   packet_bytes,
    output logic [iapsg_pkg::FRAMES_W-1:0]  packet_frames,
    output logic                            was_clamped,
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [iapsg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iapsg_pkg::RATE_W-1:0]    cfg_data
);
    import iapsg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_ACC,
        ST_DIV_NOM,
        ST_DIV_EP,
        ST_DIV_CAP,
        ST_MUL,
        ST_WRITE
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic                  issued_reg;
    logic                  issued_next;

    logic [RATE_W-1:0]     rate_reg;
    logic [RATE_W-1:0]     rate_next;
    logic [IPS_W-1:0]      ips_reg;
    logic [IPS_W-1:0]      ips_next;
    logic [FRAME_W-1:0]    frame_reg;
    logic [FRAME_W-1:0]    frame_next;
    logic [EP_W-1:0]       ep_reg;
    logic [EP_W-1:0]       ep_next;

    logic [IPS_W-1:0]      rem_reg;
    logic [IPS_W-1:0]      rem_next;
    logic [IPS_W-1:0]      new_rem_reg;
    logic [IPS_W-1:0]      new_rem_next;
    logic [DIVIDEND_W-1:0] frames_raw_reg;
    logic [DIVIDEND_W-1:0] frames_raw_next;
    logic [DIVIDEND_W-1:0] limit_reg;
    logic [DIVIDEND_W-1:0] limit_next;
    logic [FRAMES_W-1:0]   frames_reg;
    logic [FRAMES_W-1:0]   frames_next;
    logic                  clamped_reg;
    logic                  clamped_next;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [BYTES_W-1:0]    bytes_out_reg;
    logic [BYTES_W-1:0]    bytes_out_next;
    logic [FRAMES_W-1:0]   frames_out_reg;
    logic [FRAMES_W-1:0]   frames_out_next;
    logic                  clamped_out_reg;
    logic                  clamped_out_next;

    logic [RATE_W-1:0]     rate_eff;
    logic [IPS_W-1:0]      ips_eff;
    logic [FRAME_W-1:0]    frame_eff;
    logic [DIVIDEND_W-1:0] ep_frames;
    logic [FRAMES_W-1:0]   cap_frames;
    logic [FRAMES_W-1:0]   final_limit;

    div_req_t              div_req;
    div_rsp_t              div_rsp;
    mul_req_t              mul_req;
    mul_rsp_t              mul_rsp;

    // zero registers act as one
    assign rate_eff  = (rate_reg == '0)  ? RATE_W'(1)  : rate_reg;
    assign ips_eff   = (ips_reg == '0)   ? IPS_W'(1)   : ips_reg;
    assign frame_eff = (frame_reg == '0) ? FRAME_W'(1) : frame_reg;

    // endpoint frames at least one, field cap at most the frame field maximum
    assign ep_frames  = (div_rsp.quotient == '0) ? DIVIDEND_W'(1) : div_rsp.quotient;
    assign cap_frames = (div_rsp.quotient > DIVIDEND_W'(FRAMES_FIELD_MAX))
                        ? FRAMES_FIELD_MAX : div_rsp.quotient[FRAMES_W-1:0];
    assign final_limit = (limit_reg < DIVIDEND_W'(cap_frames))
                         ? limit_reg[FRAMES_W-1:0] : cap_frames;

    iapsg_serial_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    iapsg_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // operands for each division
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = ips_eff;
        div_req.steps    = STEP_W'(DIVIDEND_W);
        unique case (state_reg)
            ST_DIV_ACC:
            begin
                div_req.dividend = DIVIDEND_W'(rem_reg) + DIVIDEND_W'(rate_eff);
            end
            ST_DIV_NOM:
            begin
                div_req.dividend = {rate_eff, {(DIVIDEND_W-RATE_W){1'b0}}};
                div_req.steps    = STEP_W'(RATE_W);
            end
            ST_DIV_EP:
            begin
                div_req.dividend = {ep_reg, {(DIVIDEND_W-EP_W){1'b0}}};
                div_req.divisor  = DIVISOR_W'(frame_eff);
                div_req.steps    = STEP_W'(EP_W);
            end
            ST_DIV_CAP:
            begin
                div_req.dividend = {BYTES_FIELD_MAX, {(DIVIDEND_W-BYTES_W){1'b0}}};
                div_req.divisor  = DIVISOR_W'(frame_eff);
                div_req.steps    = STEP_W'(BYTES_W);
            end
            default:
            begin
                div_req.dividend = '0;
            end
        endcase
        if ((state_reg == ST_DIV_ACC || state_reg == ST_DIV_NOM
             || state_reg == ST_DIV_CAP
             || (state_reg == ST_DIV_EP && ep_reg != '0)) && !issued_reg)
            div_req.start = 1'b1;
    end

    // multiplier operands
    always_comb
    begin
        mul_req.start  = (state_reg == ST_MUL) && !issued_reg;
        mul_req.mcand  = frames_reg;
        mul_req.mplier = frame_eff;
    end

    // sequencer, registers and output register
    always_comb
    begin
        state_next       = state_reg;
        issued_next      = issued_reg;
        rate_next        = rate_reg;
        ips_next         = ips_reg;
        frame_next       = frame_reg;
        ep_next          = ep_reg;
        rem_next         = rem_reg;
        new_rem_next     = new_rem_reg;
        frames_raw_next  = frames_raw_reg;
        limit_next       = limit_reg;
        frames_next      = frames_reg;
        clamped_next     = clamped_reg;
        out_valid_next   = out_valid_reg;
        bytes_out_next   = bytes_out_reg;
        frames_out_next  = frames_out_reg;
        clamped_out_next = clamped_out_reg;

        // register write transfer
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SAMPLE_RATE:          rate_next  = cfg_data;
                CFG_INTERVALS_PER_SECOND: ips_next   = cfg_data[IPS_W-1:0];
                CFG_FRAME_BYTES:          frame_next = cfg_data[FRAME_W-1:0];
                CFG_ENDPOINT_MAX_PACKET:  ep_next    = cfg_data[EP_W-1:0];
            endcase
        end

        // result taken by the receiver
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                        rem_next = '0;
                    issued_next = 1'b0;
                    state_next  = ST_DIV_ACC;
                end
            end
            ST_DIV_ACC:
            begin
                if (!issued_reg)
                    issued_next = 1'b1;
                else if (div_rsp.done)
                begin
                    frames_raw_next = (div_rsp.quotient == '0)
                                      ? DIVIDEND_W'(1) : div_rsp.quotient;
                    new_rem_next    = div_rsp.remainder;
                    issued_next     = 1'b0;
                    state_next      = ST_DIV_NOM;
                end
            end
            ST_DIV_NOM:
            begin
                if (!issued_reg)
                    issued_next = 1'b1;
                else if (div_rsp.done)
                begin
                    // ceiling of rate over ips, plus one frame
                    limit_next  = div_rsp.quotient
                                  + DIVIDEND_W'(div_rsp.remainder != '0)
                                  + DIVIDEND_W'(1);
                    issued_next = 1'b0;
                    state_next  = ST_DIV_EP;
                end
            end
            ST_DIV_EP:
            begin
                if (ep_reg == '0)
                    state_next = ST_DIV_CAP;
                else if (!issued_reg)
                    issued_next = 1'b1;
                else if (div_rsp.done)
                begin
                    if (ep_frames < limit_reg)
                        limit_next = ep_frames;
                    issued_next = 1'b0;
                    state_next  = ST_DIV_CAP;
                end
            end
            ST_DIV_CAP:
            begin
                if (!issued_reg)
                    issued_next = 1'b1;
                else if (div_rsp.done)
                begin
                    // clamp clears the remainder
                    if (frames_raw_reg > DIVIDEND_W'(final_limit))
                    begin
                        frames_next  = final_limit;
                        clamped_next = 1'b1;
                        rem_next     = '0;
                    end
                    else
                    begin
                        frames_next  = frames_raw_reg[FRAMES_W-1:0];
                        clamped_next = 1'b0;
                        rem_next     = new_rem_reg;
                    end
                    issued_next = 1'b0;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (!issued_reg)
                    issued_next = 1'b1;
                else if (mul_rsp.done)
                begin
                    issued_next = 1'b0;
                    state_next  = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    bytes_out_next   = mul_rsp.product;
                    frames_out_next  = frames_reg;
                    clamped_out_next = clamped_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            issued_reg      <= 1'b0;
            rate_reg        <= RATE_RESET;
            ips_reg         <= IPS_RESET;
            frame_reg       <= FRAME_RESET;
            ep_reg          <= EP_RESET;
            rem_reg         <= '0;
            new_rem_reg     <= '0;
            frames_raw_reg  <= '0;
            limit_reg       <= '0;
            frames_reg      <= '0;
            clamped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            bytes_out_reg   <= '0;
            frames_out_reg  <= '0;
            clamped_out_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            issued_reg      <= issued_next;
            rate_reg        <= rate_next;
            ips_reg         <= ips_next;
            frame_reg       <= frame_next;
            ep_reg          <= ep_next;
            rem_reg         <= rem_next;
            new_rem_reg     <= new_rem_next;
            frames_raw_reg  <= frames_raw_next;
            limit_reg       <= limit_next;
            frames_reg      <= frames_next;
            clamped_reg     <= clamped_next;
            out_valid_reg   <= out_valid_next;
            bytes_out_reg   <= bytes_out_next;
            frames_out_reg  <= frames_out_next;
            clamped_out_reg <= clamped_out_next;
        end
    end

    assign in_stall      = (state_reg != ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign packet_bytes  = bytes_out_reg;
    assign packet_frames = frames_out_reg;
    assign was_clamped   = clamped_out_reg;

    // divider is only started when free
    a_div_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // multiplier is only started when free
    a_mul_start_free: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_rsp.busy)
        else $error("multiplier started while busy");

    // arithmetic units are quiet while waiting for an interval
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!div_rsp.busy && !mul_rsp.busy))
        else $error("arithmetic unit busy in idle");

    // every packet carries at least one frame
    a_nonzero_packet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (packet_frames != '0 && packet_bytes != '0))
        else $error("empty packet produced");

    // a clamped packet leaves a cleared remainder
    a_clamp_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && clamped_reg) |-> (rem_reg == '0))
        else $error("remainder kept after clamp");

endmodule

>>> tb/sv/iapsg_packet_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// iapsg_packet_checker
// Watches the interval, packet size and register channels of the packet size
// generator, tracks the register settings and the rate remainder on its own,
// and compares every packet size transfer against the oldest prediction.
// ============================================================================
module iapsg_packet_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            restart,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [iapsg_pkg::BYTES_W-1:0]   packet_bytes,
    input  logic [iapsg_pkg::FRAMES_W-1:0]  packet_frames,
    input  logic                            was_clamped,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [iapsg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [iapsg_pkg::RATE_W-1:0]    cfg_data,
    output int                              fail_count,
    output int                              pending
);
    import iapsg_pkg::*;

    typedef struct {
        logic [BYTES_W-1:0]  bytes;
        logic [FRAMES_W-1:0] frames;
        logic                clamped;
    } packet_size_t;

    // predicted register copies and remainder
    logic [RATE_W-1:0]  cur_rate;
    logic [IPS_W-1:0]   cur_ips;
    logic [FRAME_W-1:0] cur_frame;
    logic [EP_W-1:0]    cur_ep;
    logic [IPS_W-1:0]   carry_remainder;

    packet_size_t expected_sizes[$];

    // packet size for one interval, advances the remainder
    function automatic packet_size_t next_packet_size(input logic clear_rem);
        int unsigned  rate;
        int unsigned  ips;
        int unsigned  frame;
        int unsigned  acc;
        int unsigned  frames;
        int unsigned  limit;
        int unsigned  ep_frames;
        int unsigned  cap;
        packet_size_t ps;
        rate  = (cur_rate == 0) ? 1 : cur_rate;
        ips   = (cur_ips == 0) ? 1 : cur_ips;
        frame = (cur_frame == 0) ? 1 : cur_frame;
        ps.clamped = 1'b0;
        if (clear_rem)
            carry_remainder = '0;
        acc    = carry_remainder + rate;
        frames = acc / ips;
        carry_remainder = IPS_W'(acc % ips);
        if (frames == 0)
            frames = 1;
        // nominal ceiling, endpoint limit and field cap
        limit = (rate + ips - 1) / ips + 1;
        if (cur_ep != 0)
        begin
            ep_frames = cur_ep / frame;
            if (ep_frames == 0)
                ep_frames = 1;
            if (ep_frames < limit)
                limit = ep_frames;
        end
        cap = 131071 / frame;
        if (cap > 1023)
            cap = 1023;
        if (cap < limit)
            limit = cap;
        if (frames > limit)
        begin
            frames = limit;
            carry_remainder = '0;
            ps.clamped = 1'b1;
        end
        ps.bytes  = BYTES_W'(frames * frame);
        ps.frames = FRAMES_W'(frames);
        return ps;
    endfunction

    // channel monitor
    always @(posedge clk or negedge rst_n)
    begin
        packet_size_t want;
        packet_size_t fresh;
        if (!rst_n)
        begin
            cur_rate        = 20'd48000;
            cur_ips         = 13'd8000;
            cur_frame       = 8'd8;
            cur_ep          = '0;
            carry_remainder = '0;
            expected_sizes.delete();
            fail_count      = 0;
            pending         = 0;
        end
        else
        begin
            // register write transfer
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SAMPLE_RATE:          cur_rate  = cfg_data;
                    CFG_INTERVALS_PER_SECOND: cur_ips   = cfg_data[IPS_W-1:0];
                    CFG_FRAME_BYTES:          cur_frame = cfg_data[FRAME_W-1:0];
                    CFG_ENDPOINT_MAX_PACKET:  cur_ep    = cfg_data[EP_W-1:0];
                    default: ;
                endcase
            end
            // packet size transfer against the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_sizes.size() == 0)
                begin
                    $display("%0t unexpected packet: bytes %0d frames %0d clamped %0d",
                             $time, packet_bytes, packet_frames, was_clamped);
                    fail_count++;
                end
                else
                begin
                    want = expected_sizes.pop_front();
                    if (packet_bytes !== want.bytes)
                    begin
                        $display("%0t packet_bytes mismatch: expected %0d, actual %0d",
                                 $time, want.bytes, packet_bytes);
                        fail_count++;
                    end
                    if (packet_frames !== want.frames)
                    begin
                        $display("%0t packet_frames mismatch: expected %0d, actual %0d",
                                 $time, want.frames, packet_frames);
                        fail_count++;
                    end
                    if (was_clamped !== want.clamped)
                    begin
                        $display("%0t was_clamped mismatch: expected %0d, actual %0d",
                                 $time, want.clamped, was_clamped);
                        fail_count++;
                    end
                end
            end
            // interval transfer, prediction goes to the tail
            if (in_valid && !in_stall)
            begin
                fresh = next_packet_size(restart);
                expected_sizes.insert(expected_sizes.size(), fresh);
            end
            pending = expected_sizes.size();
        end
    end

endmodule

>>> tb/sv/iso_audio_packet_size_generator_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// iso_audio_packet_size_generator_unit_tb
// Drives service interval ticks and register settings into the packet size
// generator: a directed pass over limits, zero and oversized registers and
// remainder carry, then random settings with random receiver stalls.
// ============================================================================
module iso_audio_packet_size_generator_unit_tb;
    import iapsg_pkg::*;

    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE_WAIT  = 100;
    localparam int RAND_PHASES  = 10;
    localparam int PHASE_ITEMS  = 95;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 in_valid   = 1'b0;
    logic                 in_stall;
    logic                 restart    = 1'b0;
    logic                 out_valid;
    logic                 out_stall  = 1'b0;
    logic [BYTES_W-1:0]   packet_bytes;
    logic [FRAMES_W-1:0]  packet_frames;
    logic                 was_clamped;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [RATE_W-1:0]    cfg_data   = '0;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit idling_on    = 1'b1;

    iso_audio_packet_size_generator_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .packet_bytes (packet_bytes),
        .packet_frames(packet_frames),
        .was_clamped  (was_clamped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    iapsg_packet_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .packet_bytes (packet_bytes),
        .packet_frames(packet_frames),
        .was_clamped  (was_clamped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver stall bursts
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 9);
            out_stall  <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // one interval tick, with an optional sender gap first
    task automatic send_interval(input logic clear_rem);
        int gap;
        gap = 0;
        if (idling_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        restart  <= clear_rem;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop sending and wait until every predicted packet has been taken
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [RATE_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // all four registers, block must be idle
    task automatic program_rates(input logic [RATE_W-1:0] rate, input logic [RATE_W-1:0] ips,
                                 input logic [RATE_W-1:0] frame, input logic [RATE_W-1:0] ep);
        write_reg(CFG_SAMPLE_RATE, rate);
        write_reg(CFG_INTERVALS_PER_SECOND, ips);
        write_reg(CFG_FRAME_BYTES, frame);
        write_reg(CFG_ENDPOINT_MAX_PACKET, ep);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random setting, mostly in range, sometimes raw 20-bit words
    task automatic pick_setting();
        logic [RATE_W-1:0] rate;
        logic [RATE_W-1:0] ips;
        logic [RATE_W-1:0] frame;
        logic [RATE_W-1:0] ep;
        if ($urandom_range(0, 4) == 0)
        begin
            rate  = RATE_W'($urandom);
            ips   = RATE_W'($urandom);
            frame = RATE_W'($urandom);
            ep    = RATE_W'($urandom);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: rate = RATE_W'($urandom_range(1, 8000));
                1: rate = ($urandom_range(0, 1) == 0) ? RATE_W'(44100) : RATE_W'(768000);
                default: rate = RATE_W'($urandom_range(1, 768000));
            endcase
            case ($urandom_range(0, 2))
                0: ips = RATE_W'(1000);
                1: ips = RATE_W'(8000);
                default: ips = RATE_W'($urandom_range(1000, 8000));
            endcase
            frame = RATE_W'($urandom_range(1, 128));
            case ($urandom_range(0, 3))
                0: ep = '0;
                1: ep = RATE_W'($urandom_range(0, 3072));
                2: ep = RATE_W'($urandom_range(1, 300));
                default: ep = RATE_W'(3072);
            endcase
        end
        program_rates(rate, ips, frame, ep);
    endtask

    // stimulus and verdict
    initial
    begin
        int phase;
        int i;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings, restart on the last tick
        send_interval(1'b0);
        send_interval(1'b0);
        send_interval(1'b1);
        settle();

        // rate below one frame per interval, forced to one frame
        program_rates(20'd1, 20'd8000, 20'd1, 20'd0);
        send_interval(1'b0);
        send_interval(1'b0);
        settle();

        // largest in-range packet
        program_rates(20'd768000, 20'd1000, 20'd128, 20'd0);
        send_interval(1'b0);
        send_interval(1'b1);
        settle();

        // endpoint smaller than one frame
        program_rates(20'd96000, 20'd1000, 20'd128, 20'd1);
        send_interval(1'b0);
        send_interval(1'b0);
        settle();

        // largest endpoint limit with fractional rate
        program_rates(20'd44100, 20'd1000, 20'd6, 20'd3072);
        send_interval(1'b0);
        send_interval(1'b1);
        send_interval(1'b0);
        settle();

        // zero registers
        program_rates(20'd0, 20'd0, 20'd0, 20'd0);
        send_interval(1'b0);
        send_interval(1'b1);
        settle();

        // all-ones words, endpoint limit cuts
        program_rates(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        send_interval(1'b0);
        send_interval(1'b0);
        settle();

        // field cap acts with one interval per second
        program_rates(20'hFFFFF, 20'd0, 20'd255, 20'd0);
        send_interval(1'b0);
        settle();

        // remainder larger than a lowered ips
        program_rates(20'd7999, 20'd8000, 20'd4, 20'd0);
        send_interval(1'b0);
        send_interval(1'b0);
        settle();
        program_rates(20'd3000, 20'd1000, 20'd4, 20'd0);
        send_interval(1'b0);
        send_interval(1'b0);
        settle();

        // random settings and ticks, last phase without idling
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            idling_on = (phase == RAND_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            pick_setting();
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                send_interval($urandom_range(0, 7) == 0);
                if (phase == 3 && i == PHASE_ITEMS / 2)
                    settle();
            end
            settle();
        end

        if (fail_count == 0 && pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

>>> iso_audio_packet_size_generator_unit.f
rtl/core/iapsg_pkg.sv
rtl/core/iapsg_serial_div.sv
rtl/core/iapsg_serial_mul.sv
rtl/core/iso_audio_packet_size_generator_unit.sv
tb/sv/iapsg_packet_checker.sv
tb/sv/iso_audio_packet_size_generator_unit_tb.sv
